// File: hdl/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // Command codes carried in the action field and held in the command register.
  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_WAIT  = 3'd5;

  // Phase codes; their meaning depends on the command in progress.
  localparam logic [2:0] PH_P0 = 3'd0;
  localparam logic [2:0] PH_P1 = 3'd1;
  localparam logic [2:0] PH_P2 = 3'd2;
  localparam logic [2:0] PH_P3 = 3'd3;
  localparam logic [2:0] PH_P4 = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // Number of data bits in one byte transfer on the bus.
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_level;
  } i2cm_cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } i2cm_res_t;

endpackage

`default_nettype wire

// File: hdl/i2cm_if.sv
// Valid/ready channel interfaces of the I2C master bit engine.
// Depends on i2cm_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_cmd_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  i2cm_cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  i2cm_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: line sequencer, config registers, result skid.
// Depends on i2cm_pkg and the channel interfaces in i2cm_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Each transfer on the cmd channel is one time tick of the bus sequencer. It carries
// an action (start, stop, write byte, read byte, wait for acknowledge, or a plain
// tick), the byte to send, the acknowledge choice for a read and the sampled level
// of the data line. A command is taken only while the engine is idle; during a
// command every tick just advances the phase timers and line states.
// For every cmd transfer exactly one transfer appears on the res channel with the
// clock and data line drive (1 means released), busy, a one-tick done pulse, the
// last read byte and the no-acknowledge flag, all as they stand after that tick.
// Each result is registered, and one tick can be taken every cycle while cmd.ready
// is high: the sequencer updates its state in a single pass per tick.
// The result side is an output register plus a one-entry skid buffer, so a tick
// is still taken while one result waits; cmd.ready drops when both hold data.
// The cfg channel writes half_period_ticks (index 0) and ack_timeout (index 1);
// it is meant to be used only while the engine is idle. Both cmd.ready and
// cfg.ready stay low while reset is high, so nothing is taken during reset.
// Synchronous reset releases both lines, returns the sequencer to idle, restores
// the register defaults (5 and 250) and empties the result buffers.
module i2c_master_bit_engine_core (
  input wire logic   clk,
  input wire logic   rst,
  i2cm_cmd_if.sink   cmd,
  i2cm_res_if.source res,
  i2cm_cfg_if.sink   cfg
);
  import i2cm_pkg::*;

  // Configuration registers.
  logic [15:0] half_period_ticks;
  logic [7:0]  ack_timeout;

  // Sequencer state.
  logic [2:0]  command_reg, command_next;
  logic [2:0]  phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [7:0]  poll_count, poll_count_next;
  logic        scl_reg, scl_next;
  logic        sda_reg, sda_next;
  logic        ack_choice, ack_choice_next;
  logic        no_ack_flag, no_ack_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        done_next;

  // Result buffering.
  logic        out_valid;
  i2cm_res_t   out_data;
  logic        skid_valid;
  i2cm_res_t   skid_data;
  i2cm_res_t   result;

  logic        cmd_fire;
  logic        res_fire;
  logic [15:0] hold_m1;
  logic [3:0]  bit_count_inc;

  assign cmd.ready = !skid_valid && !rst;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res_fire  = out_valid && res.ready;
  assign cfg.ready = !rst;

  // Timer reload for a full phase; a zero half period counts as one tick.
  assign hold_m1       = (half_period_ticks == 16'd0) ? 16'd0 : half_period_ticks - 16'd1;
  assign bit_count_inc = bit_count + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RST;
      ack_timeout       <= ACK_TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HALF_PERIOD: half_period_ticks <= cfg.data;
        REG_ACK_TIMEOUT: ack_timeout <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // One tick of the sequencer.
  always_comb begin
    command_next     = command_reg;
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_next       = shift_reg;
    phase_timer_next = phase_timer;
    poll_count_next  = poll_count;
    scl_next         = scl_reg;
    sda_next         = sda_reg;
    ack_choice_next  = ack_choice;
    no_ack_next      = no_ack_flag;
    rx_hold_next     = rx_hold;
    done_next        = 1'b0;

    if (command_reg == CMD_IDLE) begin
      case (cmd.data.action)
        CMD_START: begin
          command_next     = CMD_START;
          phase_next       = PH_P0;
          scl_next         = 1'b1;
          sda_next         = 1'b1;
          phase_timer_next = hold_m1;
        end
        CMD_STOP: begin
          command_next     = CMD_STOP;
          phase_next       = PH_P0;
          scl_next         = 1'b0;
          sda_next         = 1'b0;
          phase_timer_next = hold_m1;
        end
        CMD_WRITE: begin
          command_next     = CMD_WRITE;
          bit_count_next   = 4'd0;
          shift_next       = {cmd.data.tx_byte[6:0], 1'b0};
          phase_next       = PH_P0;
          scl_next         = 1'b0;
          sda_next         = cmd.data.tx_byte[7];
          phase_timer_next = hold_m1;
        end
        CMD_READ: begin
          command_next     = CMD_READ;
          shift_next       = 8'd0;
          bit_count_next   = 4'd0;
          ack_choice_next  = cmd.data.send_ack;
          phase_next       = PH_P0;
          scl_next         = 1'b0;
          sda_next         = 1'b1;
          phase_timer_next = hold_m1;
        end
        CMD_WAIT: begin
          // The clock line keeps its current drive for the first phase.
          command_next     = CMD_WAIT;
          poll_count_next  = 8'd0;
          no_ack_next      = 1'b0;
          phase_next       = PH_P0;
          sda_next         = 1'b1;
          phase_timer_next = hold_m1;
        end
        default: ;
      endcase
    end else if (phase_timer != 16'd0) begin
      phase_timer_next = phase_timer - 16'd1;
    end else begin
      case (command_reg)
        CMD_START: begin
          if (phase == PH_P0) begin
            phase_next       = PH_P1;
            scl_next         = 1'b1;
            sda_next         = 1'b0;
            phase_timer_next = hold_m1;
          end else begin
            scl_next         = 1'b0;
            command_next     = CMD_IDLE;
            phase_next       = PH_P0;
            phase_timer_next = 16'd0;
            done_next        = 1'b1;
          end
        end
        CMD_STOP: begin
          if (phase == PH_P0) begin
            // The clock is released for exactly one tick before data rises.
            phase_next       = PH_P1;
            scl_next         = 1'b1;
            sda_next         = 1'b0;
            phase_timer_next = 16'd0;
          end else if (phase == PH_P1) begin
            phase_next       = PH_P2;
            scl_next         = 1'b1;
            sda_next         = 1'b1;
            phase_timer_next = hold_m1;
          end else begin
            command_next     = CMD_IDLE;
            phase_next       = PH_P0;
            phase_timer_next = 16'd0;
            done_next        = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (phase == PH_P0) begin
            phase_next       = PH_P1;
            scl_next         = 1'b1;
            phase_timer_next = hold_m1;
          end else if (phase == PH_P1) begin
            phase_next       = PH_P2;
            scl_next         = 1'b0;
            phase_timer_next = hold_m1;
          end else begin
            bit_count_next = bit_count_inc;
            if (bit_count_inc >= BYTE_BITS) begin
              command_next     = CMD_IDLE;
              phase_next       = PH_P0;
              phase_timer_next = 16'd0;
              done_next        = 1'b1;
            end else begin
              shift_next       = {shift_reg[6:0], 1'b0};
              phase_next       = PH_P0;
              scl_next         = 1'b0;
              sda_next         = shift_reg[7];
              phase_timer_next = hold_m1;
            end
          end
        end
        CMD_READ: begin
          if (phase == PH_P0) begin
            phase_next       = PH_P1;
            scl_next         = 1'b1;
            sda_next         = 1'b1;
            phase_timer_next = hold_m1;
          end else if (phase == PH_P1) begin
            // Sample at the end of the clock-high phase.
            shift_next       = {shift_reg[6:0], cmd.data.sda_level};
            bit_count_next   = bit_count_inc;
            scl_next         = 1'b0;
            phase_timer_next = hold_m1;
            if (bit_count_inc < BYTE_BITS) begin
              phase_next = PH_P0;
              sda_next   = 1'b1;
            end else begin
              phase_next = PH_P3;
              sda_next   = !ack_choice;
            end
          end else if (phase == PH_P3) begin
            phase_next       = PH_P4;
            scl_next         = 1'b1;
            phase_timer_next = hold_m1;
          end else begin
            scl_next         = 1'b0;
            rx_hold_next     = shift_reg;
            command_next     = CMD_IDLE;
            phase_next       = PH_P0;
            phase_timer_next = 16'd0;
            done_next        = 1'b1;
          end
        end
        CMD_WAIT: begin
          if (phase == PH_P0) begin
            phase_next       = PH_P1;
            scl_next         = 1'b1;
            sda_next         = 1'b1;
            phase_timer_next = hold_m1;
          end else if (phase == PH_P1 || phase == PH_P2) begin
            // Poll the data line once per tick with the clock high.
            phase_next = PH_P2;
            if (!cmd.data.sda_level) begin
              phase_next       = PH_P3;
              scl_next         = 1'b0;
              phase_timer_next = hold_m1;
            end else if (poll_count >= ack_timeout) begin
              // Timed out: turn the command into a stop.
              no_ack_next      = 1'b1;
              command_next     = CMD_STOP;
              phase_next       = PH_P0;
              scl_next         = 1'b0;
              sda_next         = 1'b0;
              phase_timer_next = hold_m1;
            end else begin
              poll_count_next = poll_count + 8'd1;
            end
          end else begin
            command_next     = CMD_IDLE;
            phase_next       = PH_P0;
            phase_timer_next = 16'd0;
            done_next        = 1'b1;
          end
        end
        default: begin
          command_next     = CMD_IDLE;
          phase_next       = PH_P0;
          phase_timer_next = 16'd0;
          done_next        = 1'b1;
        end
      endcase
    end

    result.scl_level   = scl_next;
    result.sda_release = sda_next;
    result.busy_res    = (command_next != CMD_IDLE);
    result.done_res    = done_next;
    result.rx_byte     = rx_hold_next;
    result.no_ack      = no_ack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_reg <= CMD_IDLE;
      phase       <= PH_P0;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      phase_timer <= 16'd0;
      poll_count  <= 8'd0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      ack_choice  <= 1'b0;
      no_ack_flag <= 1'b0;
      rx_hold     <= 8'd0;
    end else if (cmd_fire) begin
      command_reg <= command_next;
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_next;
      phase_timer <= phase_timer_next;
      poll_count  <= poll_count_next;
      scl_reg     <= scl_next;
      sda_reg     <= sda_next;
      ack_choice  <= ack_choice_next;
      no_ack_flag <= no_ack_next;
      rx_hold     <= rx_hold_next;
    end
  end

  // Output register with a one-entry skid buffer behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= cmd_fire;
      end
    end else if (cmd_fire) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire && skid_valid) begin
      out_data <= skid_data;
    end else if (cmd_fire && (!out_valid || res_fire)) begin
      out_data <= result;
    end
    if (cmd_fire && out_valid && !res_fire) begin
      skid_data <= result;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid buffer holds a result while the output register is empty");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (command_reg == CMD_IDLE) |-> (phase == PH_P0 && phase_timer == 16'd0))
    else $error("idle sequencer left a phase or timer behind");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BYTE_BITS)
    else $error("bit counter ran past one byte");

  a_timeout_stop: assert property (@(posedge clk) disable iff (rst)
    $rose(no_ack_flag) |-> (command_reg == CMD_STOP))
    else $error("acknowledge timeout did not turn into a stop");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the I2C master bit engine core.
// Depends on i2cm_pkg, the channel interfaces in i2cm_if.sv and the core itself.
`timescale 1ns / 1ps

module tb;
  import i2cm_pkg::*;

  // Action codes that the engine must ignore even when it is idle.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // How the testbench plays the bus target on the data line during a command.
  localparam int SDA_RANDOM = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_LOW    = 2;
  localparam int SDA_ACK_AT = 3;

  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  // Rough number of bus ticks the whole run aims for.
  localparam int ITEM_TARGET = 400;

  // Full state of the line sequencer, including its two configuration registers.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  phase;
    logic [3:0]  bits;
    logic [7:0]  shreg;
    logic [15:0] timer;
    logic [7:0]  polls;
    logic        scl;
    logic        sda;
    logic        ack_sel;
    logic        nack;
    logic        done;
    logic [7:0]  rx;
    logic [15:0] half;
    logic [7:0]  tmo;
  } line_state_t;

  // One entry of the stimulus stream: either a bus tick or a register write.
  typedef struct packed {
    logic        is_cfg;
    logic        cfg_idx;
    logic [15:0] cfg_val;
    i2cm_cmd_t   item;
  } tick_entry_t;

  logic clk;
  logic rst;

  i2cm_cmd_if cmd_ch ();
  i2cm_res_if res_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_master_bit_engine_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // The stimulus stream, the predicted line states, and the two copies of the
  // sequencer state: one used to plan stimulus, one advanced on real transfers.
  tick_entry_t tick_q[$];
  i2cm_res_t   bus_result_q[$];
  line_state_t plan_st;
  line_state_t line_st;

  int cmds_issued   = 0;
  int ticks_planned = 0;
  int ticks_sent    = 0;
  int regs_written  = 0;
  int lines_checked = 0;
  int mismatches    = 0;
  int in_flight     = 0;
  int burst_left    = 0;
  int gap_left      = 0;
  int quiet_cycles  = 0;
  int rx_cycle      = 0;

  // ---------------------------------------------------------------------------
  // Line sequencer predictor.
  // ---------------------------------------------------------------------------

  function automatic line_state_t reset_state();
    line_state_t s;
    s = '0;
    s.cmd  = CMD_IDLE;
    s.phase = PH_P0;
    s.scl  = 1'b1;
    s.sda  = 1'b1;
    s.half = HALF_PERIOD_RST;
    s.tmo  = ACK_TIMEOUT_RST;
    return s;
  endfunction

  // A half period of zero behaves like a single tick.
  function automatic logic [16:0] hold_ticks(line_state_t s);
    return (s.half == 16'd0) ? 17'd1 : {1'b0, s.half};
  endfunction

  // Start a phase: set both lines and hold them for the given number of ticks.
  function automatic line_state_t enter_phase(line_state_t s, logic [2:0] ph, logic scl,
                                              logic sda, logic [16:0] ticks);
    logic [16:0] left;
    left = ticks - 17'd1;
    s.phase = ph;
    s.scl   = scl;
    s.sda   = sda;
    s.timer = left[15:0];
    return s;
  endfunction

  function automatic line_state_t finish_cmd(line_state_t s);
    s.cmd   = CMD_IDLE;
    s.phase = PH_P0;
    s.timer = 16'd0;
    s.done  = 1'b1;
    return s;
  endfunction

  // Put the next data bit on the line, most significant bit first.
  function automatic line_state_t write_bit(line_state_t s);
    logic b;
    b = s.shreg[7];
    s.shreg = {s.shreg[6:0], 1'b0};
    return enter_phase(s, PH_P0, 1'b0, b, hold_ticks(s));
  endfunction

  // One poll of the data line while the clock is high during an acknowledge wait.
  // Running past the timeout turns the command into a stop and flags no_ack.
  function automatic line_state_t poll_ack(line_state_t s, logic sda_in);
    if (!sda_in) begin
      s = enter_phase(s, PH_P3, 1'b0, s.sda, hold_ticks(s));
    end else if (s.polls >= s.tmo) begin
      s.nack = 1'b1;
      s.cmd  = CMD_STOP;
      s = enter_phase(s, PH_P0, 1'b0, 1'b0, hold_ticks(s));
    end else begin
      s.polls = s.polls + 8'd1;
    end
    return s;
  endfunction

  // Advance the sequencer by one tick.
  function automatic line_state_t tick_line(line_state_t s, i2cm_cmd_t c);
    logic [16:0] h;
    h = hold_ticks(s);
    s.done = 1'b0;
    if (s.cmd == CMD_IDLE) begin
      case (c.action)
        CMD_START: begin
          s.cmd = CMD_START;
          s = enter_phase(s, PH_P0, 1'b1, 1'b1, h);
        end
        CMD_STOP: begin
          s.cmd = CMD_STOP;
          s = enter_phase(s, PH_P0, 1'b0, 1'b0, h);
        end
        CMD_WRITE: begin
          s.cmd   = CMD_WRITE;
          s.shreg = c.tx_byte;
          s.bits  = 4'd0;
          s = write_bit(s);
        end
        CMD_READ: begin
          s.cmd     = CMD_READ;
          s.shreg   = 8'd0;
          s.bits    = 4'd0;
          s.ack_sel = c.send_ack;
          s = enter_phase(s, PH_P0, 1'b0, 1'b1, h);
        end
        CMD_WAIT: begin
          s.cmd   = CMD_WAIT;
          s.polls = 8'd0;
          s.nack  = 1'b0;
          s = enter_phase(s, PH_P0, s.scl, 1'b1, h);
        end
        default: begin
        end
      endcase
    end else if (s.timer != 16'd0) begin
      s.timer = s.timer - 16'd1;
    end else begin
      case (s.cmd)
        CMD_START: begin
          if (s.phase == PH_P0) begin
            s = enter_phase(s, PH_P1, 1'b1, 1'b0, h);
          end else begin
            s.scl = 1'b0;
            s = finish_cmd(s);
          end
        end
        CMD_STOP: begin
          if (s.phase == PH_P0) begin
            s = enter_phase(s, PH_P1, 1'b1, 1'b0, 17'd1);
          end else if (s.phase == PH_P1) begin
            s = enter_phase(s, PH_P2, 1'b1, 1'b1, h);
          end else begin
            s = finish_cmd(s);
          end
        end
        CMD_WRITE: begin
          if (s.phase == PH_P0) begin
            s = enter_phase(s, PH_P1, 1'b1, s.sda, h);
          end else if (s.phase == PH_P1) begin
            s = enter_phase(s, PH_P2, 1'b0, s.sda, h);
          end else begin
            s.bits = s.bits + 4'd1;
            if (s.bits >= BYTE_BITS) s = finish_cmd(s);
            else s = write_bit(s);
          end
        end
        CMD_READ: begin
          if (s.phase == PH_P0) begin
            s = enter_phase(s, PH_P1, 1'b1, 1'b1, h);
          end else if (s.phase == PH_P1) begin
            s.shreg = {s.shreg[6:0], c.sda_level};
            s.bits  = s.bits + 4'd1;
            if (s.bits < BYTE_BITS) s = enter_phase(s, PH_P0, 1'b0, 1'b1, h);
            else s = enter_phase(s, PH_P3, 1'b0, !s.ack_sel, h);
          end else if (s.phase == PH_P3) begin
            s = enter_phase(s, PH_P4, 1'b1, s.sda, h);
          end else begin
            s.scl = 1'b0;
            s.rx  = s.shreg;
            s = finish_cmd(s);
          end
        end
        CMD_WAIT: begin
          if (s.phase == PH_P0) begin
            s = enter_phase(s, PH_P1, 1'b1, 1'b1, h);
          end else if (s.phase == PH_P1) begin
            s.phase = PH_P2;
            s = poll_ack(s, c.sda_level);
          end else if (s.phase == PH_P2) begin
            s = poll_ack(s, c.sda_level);
          end else begin
            s = finish_cmd(s);
          end
        end
        default: s = finish_cmd(s);
      endcase
    end
    return s;
  endfunction

  function automatic line_state_t write_reg(line_state_t s, logic idx, logic [15:0] val);
    if (idx == REG_HALF_PERIOD) s.half = val;
    else s.tmo = val[7:0];
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning. The planning copy of the sequencer tells the generator
  // when a command is still running, so the next one lands right after done.
  // ---------------------------------------------------------------------------

  task automatic push_tick(int act, int tx, int ack, int sda);
    tick_entry_t e;
    e = '0;
    e.item.action    = act[2:0];
    e.item.tx_byte   = tx[7:0];
    e.item.send_ack  = ack[0];
    e.item.sda_level = sda[0];
    plan_st = tick_line(plan_st, e.item);
    tick_q.push_back(e);
    ticks_planned++;
  endtask

  task automatic push_cfg(logic idx, int val);
    tick_entry_t e;
    e = '0;
    e.is_cfg  = 1'b1;
    e.cfg_idx = idx;
    e.cfg_val = val[15:0];
    plan_st = write_reg(plan_st, idx, e.cfg_val);
    tick_q.push_back(e);
  endtask

  // Level the bus target puts on the data line n ticks into a command.
  function automatic int line_level(int mode, int delay, int n);
    case (mode)
      SDA_HIGH:   return 1;
      SDA_LOW:    return 0;
      SDA_ACK_AT: return (n >= delay) ? 0 : 1;
      default:    return $urandom_range(0, 1);
    endcase
  endfunction

  // Offer one command, then keep ticking until it completes. Some of the busy
  // ticks carry stray commands, which the engine has to ignore. A few idle
  // ticks with the plain idle code or an unused action code may follow.
  task automatic issue(int act, int tx, int ack, int sda_mode, int delay);
    int n;
    int r;
    n = 0;
    push_tick(act, tx, ack, line_level(sda_mode, delay, 0));
    if (plan_st.cmd != CMD_IDLE) cmds_issued++;
    while (plan_st.cmd != CMD_IDLE) begin
      n++;
      r = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : CMD_IDLE;
      push_tick(r, $urandom, $urandom_range(0, 1), line_level(sda_mode, delay, n));
    end
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(0, 2);
      push_tick((r == 0) ? CMD_IDLE : (r == 1) ? ACT_SPARE_LO : ACT_SPARE_HI,
                $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  // Wait for acknowledge: usually the target pulls the line low after a random
  // delay that can fall before, during or after the timeout window.
  task automatic await_ack();
    int span;
    span = 2 * hold_ticks(plan_st) + plan_st.tmo + 2;
    if ($urandom_range(0, 5) == 0) issue(CMD_WAIT, $urandom, 0, SDA_HIGH, 0);
    else issue(CMD_WAIT, $urandom, 0, SDA_ACK_AT, $urandom_range(0, span));
  endtask

  // A well-formed bus transaction: start, address, acknowledge, one or two
  // data bytes in either direction, and usually a stop.
  task automatic bus_transaction();
    issue(CMD_START, $urandom, 0, SDA_RANDOM, 0);
    issue(CMD_WRITE, $urandom, 0, SDA_RANDOM, 0);
    await_ack();
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 1) == 1) begin
        issue(CMD_WRITE, $urandom, 0, SDA_RANDOM, 0);
        await_ack();
      end else begin
        issue(CMD_READ, $urandom, $urandom_range(0, 1), SDA_RANDOM, 0);
      end
    end
    if ($urandom_range(0, 4) != 0) issue(CMD_STOP, $urandom, 0, SDA_RANDOM, 0);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver. Ticks go out in bursts of random length separated by random gaps;
  // a valid that is up stays up until its transfer. Register writes wait until
  // every accepted tick has produced its result, so they only hit an idle engine.
  // The prediction is made here, on the transfer itself.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic        cmd_fire;
    logic        cfg_fire;
    logic        res_fire;
    logic        nxt_cmd_valid;
    logic        nxt_cfg_valid;
    tick_entry_t head;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      line_st    = reset_state();
      in_flight  = 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      cmd_fire = cmd_ch.valid && cmd_ch.ready;
      cfg_fire = cfg_ch.valid && cfg_ch.ready;
      res_fire = res_ch.valid && res_ch.ready;
      if (cmd_fire) begin
        line_st = tick_line(line_st, cmd_ch.data);
        bus_result_q.push_back('{scl_level:   line_st.scl,
                                 sda_release: line_st.sda,
                                 busy_res:    line_st.cmd != CMD_IDLE,
                                 done_res:    line_st.done,
                                 rx_byte:     line_st.rx,
                                 no_ack:      line_st.nack});
        head = tick_q.pop_front();
        ticks_sent++;
      end
      if (cfg_fire) begin
        line_st = write_reg(line_st, cfg_ch.index, cfg_ch.data);
        head = tick_q.pop_front();
        regs_written++;
      end
      in_flight = in_flight + (cmd_fire ? 1 : 0) - (res_fire ? 1 : 0);

      nxt_cmd_valid = 1'b0;
      nxt_cfg_valid = 1'b0;
      if (cmd_ch.valid && !cmd_fire) begin
        nxt_cmd_valid = 1'b1;
      end else if (cfg_ch.valid && !cfg_fire) begin
        nxt_cfg_valid = 1'b1;
      end else if (tick_q.size() != 0) begin
        head = tick_q[0];
        if (head.is_cfg) begin
          if (in_flight == 0) begin
            nxt_cfg_valid = 1'b1;
            cfg_ch.index <= head.cfg_idx;
            cfg_ch.data  <= head.cfg_val;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          nxt_cmd_valid = 1'b1;
          cmd_ch.data <= head.item;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // Six bursts in ten run straight into the next one.
            case ($urandom_range(0, 9))
              0:       gap_left = $urandom_range(10, 30);
              1, 2, 3: gap_left = $urandom_range(1, 6);
              default: gap_left = 0;
            endcase
            burst_left = $urandom_range(1, 40);
          end
        end
      end
      cmd_ch.valid <= nxt_cmd_valid;
      cfg_ch.valid <= nxt_cfg_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result transfer is checked against the oldest prediction.
  // The receiver's ready steps in turn through patterns: fully open, a regular
  // one-in-four stall, coin flips, a long periodic stall, and random stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    i2cm_res_t want;
    logic      rdy;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_cycle = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (bus_result_q.size() == 0) begin
          $error("result transfer arrived with no prediction waiting");
          mismatches++;
        end else begin
          want = bus_result_q.pop_front();
          check_field("scl_level", want.scl_level, res_ch.data.scl_level);
          check_field("sda_release", want.sda_release, res_ch.data.sda_release);
          check_field("busy_res", want.busy_res, res_ch.data.busy_res);
          check_field("done_res", want.done_res, res_ch.data.done_res);
          check_field("rx_byte", want.rx_byte, res_ch.data.rx_byte);
          check_field("no_ack", want.no_ack, res_ch.data.no_ack);
          lines_checked++;
        end
      end
      rx_cycle++;
      case (rx_cycle[8:6])
        3'd0, 3'd1: rdy = 1'b1;
        3'd2:       rdy = (rx_cycle[1:0] != 2'd0);
        3'd3:       rdy = ($urandom_range(0, 1) == 1);
        3'd4:       rdy = (rx_cycle[4:0] < 5'd20);
        default:    rdy = ($urandom_range(0, 3) != 0);
      endcase
      res_ch.ready <= rdy;
    end
  end

  // Watchdog: a long stretch without any transfer means the engine is stuck.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int half_now;
    int tmo_now;
    int rand_base;
    int phase_end;
    clk          = 1'b0;
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = 1'b0;
    cfg_ch.data  = 16'd0;
    res_ch.ready = 1'b0;
    plan_st = reset_state();

    // Directed part, first on the reset values of both registers: a start, an
    // immediate acknowledge and a stop.
    issue(CMD_START, 0, 0, SDA_RANDOM, 0);
    issue(CMD_WAIT, 0, 0, SDA_LOW, 0);
    issue(CMD_STOP, 0, 0, SDA_RANDOM, 0);
    // Unused action codes while idle do nothing.
    push_tick(ACT_SPARE_LO, 8'hFF, 1, 1);
    push_tick(ACT_SPARE_HI, 8'h00, 0, 0);
    push_tick(CMD_IDLE, 8'h5A, 1, 0);

    // A zero half period acts as one tick; a zero timeout gives up on the
    // first high poll. Bytes at the extremes, reads of all ones and all zeros
    // with and without acknowledge.
    push_cfg(REG_HALF_PERIOD, 0);
    push_cfg(REG_ACK_TIMEOUT, 0);
    issue(CMD_START, 0, 0, SDA_RANDOM, 0);
    issue(CMD_WRITE, 8'h00, 0, SDA_RANDOM, 0);
    issue(CMD_WAIT, 0, 0, SDA_LOW, 0);
    issue(CMD_WRITE, 8'hFF, 0, SDA_RANDOM, 0);
    issue(CMD_WAIT, 0, 0, SDA_HIGH, 0);
    issue(CMD_READ, 0, 1, SDA_HIGH, 0);
    issue(CMD_READ, 0, 0, SDA_LOW, 0);
    issue(CMD_STOP, 0, 0, SDA_RANDOM, 0);
    // A wait accepted with the clock still released after a stop.
    issue(CMD_WAIT, 0, 0, SDA_ACK_AT, 2);

    // The longest acknowledge window, answered partway through, then a short
    // window run out to its timeout.
    push_cfg(REG_HALF_PERIOD, 1);
    push_cfg(REG_ACK_TIMEOUT, 8'hFF);
    issue(CMD_WAIT, 0, 0, SDA_ACK_AT, 24);
    push_cfg(REG_ACK_TIMEOUT, 1);
    issue(CMD_WAIT, 0, 0, SDA_HIGH, 0);

    // Random part in several register settings, sharing what is left of the
    // tick budget. Most traffic is well-formed transactions; the rest is single
    // commands of any code, including ones that arrive out of order.
    rand_base = ticks_planned;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          half_now = 1;
          tmo_now  = $urandom_range(1, 8);
        end
        1: begin
          half_now = $urandom_range(0, 1);
          tmo_now  = 0;
        end
        default: begin
          half_now = $urandom_range(1, 2);
          tmo_now  = $urandom_range(1, 12);
        end
      endcase
      push_cfg(REG_HALF_PERIOD, half_now);
      push_cfg(REG_ACK_TIMEOUT, tmo_now);
      phase_end = rand_base + (ITEM_TARGET - rand_base) * (ph + 1) / 3;
      while (ticks_planned < phase_end) begin
        if ($urandom_range(0, 1) != 0) begin
          bus_transaction();
        end else begin
          issue($urandom_range(0, 7), $urandom, $urandom_range(0, 1), SDA_ACK_AT,
                $urandom_range(0, 2 * half_now + tmo_now + 2));
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: all ticks sent and every predicted line state seen, then a short
    // tail to catch any result that should not be there.
    do @(posedge clk); while (tick_q.size() != 0 || bus_result_q.size() != 0);
    repeat (4) @(posedge clk);

    $display("Covered %0d bus commands over %0d ticks and %0d register writes.",
             cmds_issued, ticks_sent, regs_written);
    $display("Checked %0d line states, %0d mismatches.", lines_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
